// ===== hw/rtl/button_click_long_press_fsm_assert.svh =====
// Assertion macros for the button click / long-press block.
// Define ASSERT_OFF to compile the checks out.
`ifndef BUTTON_CLICK_LONG_PRESS_FSM_ASSERT_SVH
`define BUTTON_CLICK_LONG_PRESS_FSM_ASSERT_SVH

`ifndef ASSERT_OFF

// Condition a implies condition b in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed: same-cycle implication");

// Condition a implies condition b in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

// ===== hw/rtl/btnlp_pkg.sv =====
package btnlp_pkg;

   // Field widths
   localparam int TIME_W  = 32;
   localparam int THR_W   = 31;
   localparam int IDX_W   = 2;
   localparam int EVENT_W = 2;

   // Register indexes
   localparam logic [IDX_W-1:0] CSR_PRESS_DEBOUNCE   = 2'd0;
   localparam logic [IDX_W-1:0] CSR_RELEASE_DEBOUNCE = 2'd1;
   localparam logic [IDX_W-1:0] CSR_LONG_PRESS       = 2'd2;

   // Register reset values
   localparam logic [THR_W-1:0] PRESS_DEBOUNCE_RST   = 31'd20;
   localparam logic [THR_W-1:0] RELEASE_DEBOUNCE_RST = 31'd20;
   localparam logic [THR_W-1:0] LONG_PRESS_RST       = 31'd1000;

   typedef enum logic [1:0] {
      ST_IDLE     = 2'd0,
      ST_DEB_DOWN = 2'd1,
      ST_HOLDING  = 2'd2,
      ST_DEB_UP   = 2'd3
   } state_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE  = 2'd0,
      EV_CLICK = 2'd1,
      EV_LONG  = 2'd2
   } event_type;

   typedef struct packed {
      logic [THR_W-1:0] press_debounce_ms;
      logic [THR_W-1:0] release_debounce_ms;
      logic [THR_W-1:0] long_press_ms;
   } cfg_type;

endpackage

// ===== hw/rtl/btnlp_ifs.sv =====
// Poll channel: timestamp and sampled button level
interface btnlp_req_if;
   logic                          valid;
   logic                          ready;
   logic [btnlp_pkg::TIME_W-1:0]  now_ms;
   logic                          button_down;

   modport source (output valid, output now_ms, output button_down, input ready);
   modport sink   (input valid, input now_ms, input button_down, output ready);
endinterface

// Event channel: one event code per poll
interface btnlp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [btnlp_pkg::EVENT_W-1:0] event_res;

   modport source (output valid, output event_res, input ready);
   modport sink   (input valid, input event_res, output ready);
endinterface

// ===== hw/rtl/button_click_long_press_fsm.sv =====
// Button click / long-press detector.
// An accepted poll passes through the input register, then the result register, to its event.
// Throughput: one poll per cycle; the input register and the result register
// each advance whenever the stage after them is free or drained.
// Reset (synchronous, active high): machine idle, last level up, registers at
// 20 / 20 / 1000 ms, both pipeline stages empty.
`include "button_click_long_press_fsm_assert.svh"

module button_click_long_press_fsm (
   input  logic                          clock,
   input  logic                          reset,
   btnlp_req_if.sink                     req_chan,
   btnlp_rsp_if.source                   rsp_chan,
   input  logic                          csr_we,
   input  logic [btnlp_pkg::IDX_W-1:0]   csr_index,
   input  logic [btnlp_pkg::THR_W-1:0]   csr_wdata
);

   btnlp_pkg::cfg_type            cfg;
   btnlp_pkg::event_type          event_comb;

   logic                          in_valid_ff, in_valid_in;
   logic [btnlp_pkg::TIME_W-1:0]  in_now_ff;
   logic                          in_down_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   btnlp_pkg::event_type          rsp_event_ff;
   logic                          advance;
   logic                          req_take;

   btnlp_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   btnlp_fsm u_fsm (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .now_ms      (in_now_ff),
      .button_down (in_down_ff),
      .cfg         (cfg),
      .event_res   (event_comb)
   );

   // Move a transaction from the input register to the result register
   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;
   assign in_valid_in    = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in   = advance || (rsp_valid_ff && !rsp_chan.ready);

   // Stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture payloads; hold while stalled
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_now_ff  <= req_chan.now_ms;
         in_down_ff <= req_chan.button_down;
      end
      if (advance) begin
         rsp_event_ff <= event_comb;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.event_res = rsp_event_ff;

   // A taken poll sits in the input register next cycle
   `ASSERT_NEXT(a_take_fills, clock, reset, req_take, in_valid_ff)
   // A step always lands in the result register
   `ASSERT_NEXT(a_step_lands, clock, reset, advance, rsp_valid_ff)
   // A blocked poll is not dropped
   `ASSERT_NEXT(a_hold_input, clock, reset, in_valid_ff && !advance, in_valid_ff)
   // Only a full input register steps the machine
   `ASSERT_IMPLIES(a_step_needs_item, clock, reset, advance, in_valid_ff)

endmodule

// ===== hw/rtl/btnlp_cfg.sv =====
module btnlp_cfg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [btnlp_pkg::IDX_W-1:0]   csr_index,
   input  logic [btnlp_pkg::THR_W-1:0]   csr_wdata,
   output btnlp_pkg::cfg_type            cfg
);

   btnlp_pkg::cfg_type cfg_ff;
   btnlp_pkg::cfg_type cfg_in;

   // Decode the write; unknown indexes change nothing
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            btnlp_pkg::CSR_PRESS_DEBOUNCE:   cfg_in.press_debounce_ms   = csr_wdata;
            btnlp_pkg::CSR_RELEASE_DEBOUNCE: cfg_in.release_debounce_ms = csr_wdata;
            btnlp_pkg::CSR_LONG_PRESS:       cfg_in.long_press_ms       = csr_wdata;
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_debounce_ms   <= btnlp_pkg::PRESS_DEBOUNCE_RST;
         cfg_ff.release_debounce_ms <= btnlp_pkg::RELEASE_DEBOUNCE_RST;
         cfg_ff.long_press_ms       <= btnlp_pkg::LONG_PRESS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/btnlp_fsm.sv =====
module btnlp_fsm (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [btnlp_pkg::TIME_W-1:0]  now_ms,
   input  logic                          button_down,
   input  btnlp_pkg::cfg_type            cfg,
   output btnlp_pkg::event_type          event_res
);

   btnlp_pkg::state_type          state_ff, state_in;
   logic [btnlp_pkg::TIME_W-1:0]  mark_ff, mark_in;
   logic [btnlp_pkg::TIME_W-1:0]  press_ff, press_in;
   logic                          long_done_ff, long_done_in;
   logic                          prev_down_ff, prev_down_in;

   // Wrapping difference read as signed: passed when non-negative and at threshold
   function automatic logic elapsed(input logic [btnlp_pkg::TIME_W-1:0] now,
                                    input logic [btnlp_pkg::TIME_W-1:0] since,
                                    input logic [btnlp_pkg::THR_W-1:0]  thr);
      logic [btnlp_pkg::TIME_W-1:0] diff;
      diff = now - since;
      return !diff[btnlp_pkg::TIME_W-1] && (diff[btnlp_pkg::THR_W-1:0] >= thr);
   endfunction

   // Next state and event for the transaction in the input register
   always_comb begin
      state_in     = state_ff;
      mark_in      = mark_ff;
      press_in     = press_ff;
      long_done_in = long_done_ff;
      prev_down_in = prev_down_ff;
      event_res    = btnlp_pkg::EV_NONE;
      if (step) begin
         prev_down_in = button_down;
         unique case (state_ff)
            btnlp_pkg::ST_IDLE: begin
               if (!prev_down_ff && button_down) begin
                  state_in = btnlp_pkg::ST_DEB_DOWN;
                  mark_in  = now_ms;
               end
            end
            btnlp_pkg::ST_DEB_DOWN: begin
               if (elapsed(now_ms, mark_ff, cfg.press_debounce_ms)) begin
                  if (button_down) begin
                     state_in     = btnlp_pkg::ST_HOLDING;
                     press_in     = now_ms;
                     long_done_in = 1'b0;
                  end else begin
                     state_in = btnlp_pkg::ST_IDLE;
                  end
               end
            end
            btnlp_pkg::ST_HOLDING: begin
               // Long event step leaves everything else, the last level too
               if (!long_done_ff && elapsed(now_ms, press_ff, cfg.long_press_ms)) begin
                  long_done_in = 1'b1;
                  prev_down_in = prev_down_ff;
                  event_res    = btnlp_pkg::EV_LONG;
               end else if (!button_down) begin
                  state_in = btnlp_pkg::ST_DEB_UP;
                  mark_in  = now_ms;
               end
            end
            btnlp_pkg::ST_DEB_UP: begin
               if (elapsed(now_ms, mark_ff, cfg.release_debounce_ms)) begin
                  if (!button_down) begin
                     state_in  = btnlp_pkg::ST_IDLE;
                     event_res = long_done_ff ? btnlp_pkg::EV_NONE : btnlp_pkg::EV_CLICK;
                  end else begin
                     state_in = btnlp_pkg::ST_HOLDING;
                  end
               end
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= btnlp_pkg::ST_IDLE;
         long_done_ff <= 1'b0;
         prev_down_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         long_done_ff <= long_done_in;
         prev_down_ff <= prev_down_in;
      end
   end

   // Timestamps are written before they are read
   always_ff @(posedge clock) begin
      mark_ff  <= mark_in;
      press_ff <= press_in;
   end

endmodule
